// ----- sv/dwm_pkg.sv -----
// Shared constants and types for the distinct window marker finder.
package dwm_pkg;

    // Deepest window the history holds
    localparam int WINDOW_MAX = 16;
    // Width of a window length or a fill count (holds WINDOW_MAX itself)
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    // Shortest window that makes sense
    localparam int WINDOW_MIN = 2;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int POS_W = 32;
    localparam int WLEN_W = 5;

    // Configuration bus
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
    localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = 5'd14;

    // One result word
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] marker_end;
    } res_t;

endpackage

// ----- sv/distinct_window_marker_finder_core.sv -----
// Top level of the distinct window marker finder: input stage, scan core, result handshake.
//
// Finds the first place in a byte stream where the last window_len bytes are all
// different and reports the 1-based count of the byte that closed that window.
// Every accepted byte yields one result word (found, marker_end); after a marker
// is found the result stays frozen until reset. The block takes one byte per
// clock while out_ready is high. A byte is held in the input register, then the
// pairwise comparator array over the 16-entry history settles its result into
// the result registers, where the result word is presented until out_ready
// takes it. While out_ready is low the input register holds one more byte and
// then in_ready drops. window_len (reset 14, clamped to 2..16) is written over
// the APB-style port at address 0 while the block is idle; the block itself
// does not enforce this, so the user must keep to it.
module distinct_window_marker_finder_core
    import dwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BYTE_W-1:0]  data_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic [POS_W-1:0]   marker_end,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              step;
    logic              in_take;
    logic [WLEN_W-1:0] window_len;
    res_t              res;

    dwm_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .window_len (window_len)
    );

    // Move the held word into the scan when the result slot is free
    assign step     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || step;
    assign in_take  = in_valid && in_ready;

    dwm_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (s1_byte_reg),
        .window_len (window_len),
        .res        (res)
    );

    // Input stage control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Result stage control: hold until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming byte
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = res.found;
    assign marker_end = res.marker_end;

`ifndef NO_ASSERTIONS
    // Once found, the flag never drops
    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        found |=> found)
        else $error("found flag dropped");

    // Once found, the position is frozen
    a_pos_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        found |=> $stable(marker_end))
        else $error("marker position changed after marker");

    // Never overwrite a held input word that has not moved on
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_take && s1_valid_reg && !step))
        else $error("input stage overrun");

    // A scan step always produces a visible result next cycle
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("result lost after scan step");
`endif

endmodule

// ----- sv/dwm_cfg.sv -----
// APB-style register port holding the window length.
module dwm_cfg
    import dwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [WLEN_W-1:0]  window_len
);

    logic [WLEN_W-1:0]    window_len_reg;
    logic [WLEN_W-1:0]    window_len_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Decode the register index from the word address
    assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Load the window length on a write to its address
    always_comb
    begin
        window_len_next = window_len_reg;
        if (wr_en && (reg_idx == REG_WINDOW_LEN))
        begin
            window_len_next = pwdata[WLEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RST;
        end
        else
        begin
            window_len_reg <= window_len_next;
        end
    end

    // Return the register value, zero elsewhere
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_WINDOW_LEN)
        begin
            prdata = {{(PDATA_W - WLEN_W){1'b0}}, window_len_reg};
        end
    end

    assign window_len = window_len_reg;

endmodule

// ----- sv/dwm_scan.sv -----
// History window, byte counter and distinct-window check with latched result.
module dwm_scan
    import dwm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [WLEN_W-1:0] window_len,
    output res_t              res
);

    logic [BYTE_W-1:0] hist_reg  [WINDOW_MAX];
    logic [BYTE_W-1:0] hist_next [WINDOW_MAX];
    logic [LEN_W-1:0]  filled_reg;
    logic [LEN_W-1:0]  filled_next;
    logic [POS_W-1:0]  count_reg;
    logic [POS_W-1:0]  count_next;
    logic              seen_reg;
    logic              seen_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [LEN_W-1:0]  eff_len;
    logic              distinct;

    // Clamp the window length into the supported range
    always_comb
    begin
        if (window_len < WLEN_W'(WINDOW_MIN))
        begin
            eff_len = LEN_W'(WINDOW_MIN);
        end
        else if (window_len > WLEN_W'(WINDOW_MAX))
        begin
            eff_len = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len = LEN_W'(window_len);
        end
    end

    // Shift the new byte in at the front
    always_comb
    begin
        hist_next[0] = data_byte;
        for (int k = 1; k < WINDOW_MAX; k++)
        begin
            hist_next[k] = hist_reg[k-1];
        end
    end

    // Advance the fill count and byte count, both saturating
    assign filled_next = (filled_reg == LEN_W'(WINDOW_MAX)) ? filled_reg
                                                             : filled_reg + 1'b1;
    assign count_next  = (count_reg == {POS_W{1'b1}}) ? count_reg : count_reg + 1'b1;

    // Compare every pair inside the active window
    always_comb
    begin
        distinct = 1'b1;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            for (int j = i + 1; j < WINDOW_MAX; j++)
            begin
                if ((LEN_W'(j) < eff_len) && (hist_next[i] == hist_next[j]))
                begin
                    distinct = 1'b0;
                end
            end
        end
    end

    // Latch the marker position the first time the window is all distinct
    always_comb
    begin
        seen_next = seen_reg;
        pos_next  = pos_reg;
        if ((filled_next >= eff_len) && distinct)
        begin
            seen_next = 1'b1;
            pos_next  = count_next;
        end
    end

    // History payload: advance only while searching
    always_ff @(posedge clk)
    begin
        if (step && !seen_reg)
        begin
            hist_reg <= hist_next;
        end
    end

    // Counters and result; freeze once a marker is seen
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            count_reg  <= '0;
            seen_reg   <= 1'b0;
            pos_reg    <= '0;
        end
        else if (step && !seen_reg)
        begin
            filled_reg <= filled_next;
            count_reg  <= count_next;
            seen_reg   <= seen_next;
            pos_reg    <= pos_next;
        end
    end

    assign res.found      = seen_reg;
    assign res.marker_end = pos_reg;

endmodule
